FILE: rtl/rcq_pkg.sv
// Shared types and constants for the range convoy query queue.
// Holds action and status codes, bound layout, stream widths and sequencer states.
// No dependencies.
`default_nettype none

package rcq_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int TAG_BITS_DEF    = 16;

    localparam int VALUE_W  = 32;
    localparam int BOUND_W  = VALUE_W + 1;
    localparam int IN_TAG_W = 16;
    localparam int OCC_W    = 7;
    localparam int S_DATA_W = 88;
    localparam int M_DATA_W = 96;

    localparam logic [1:0] ACT_APPEND = 2'd0;
    localparam logic [1:0] ACT_CONVOY = 2'd1;
    localparam logic [1:0] ACT_POP    = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic                      is_null;
        logic [VALUE_W-1:0]        value;
    } bound_t;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_ALLOC = 7'b0000010,
        ST_WRITE = 7'b0000100,
        ST_WALK  = 7'b0001000,
        ST_LINK2 = 7'b0010000,
        ST_POP   = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    // Equal bounds: null matches only null, otherwise the values match.
    function automatic logic bound_eq(input bound_t a, input bound_t b);
        logic eq;
        if (a.is_null || b.is_null)
            eq = a.is_null && b.is_null;
        else
            eq = (a.value == b.value);
        return eq;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/range_convoy_query_queue.sv
// Top level of the range convoy query queue: sequencer, entry and link memories.
// Depends on rcq_pkg.
// Ordered queue of range queries kept as a linked list in two synchronous memories.
//
// One item is worked at a time; each gives one result. A push goes through the alloc state
// when its slot comes off the free chain and then the write state, a pop through the pop
// state, and a rejected item or the unused action code straight to the done state. A convoy
// push then walks the list, visiting up to the occupancy, since the walk reads one linked
// entry per cycle through the read port of the entry and link memories. It needs the link
// state when it is linked in after an entry or before a later one, but not when it lands
// before the head or at the tail. The next item is taken once the result has moved into the
// output register, which waits until that register is free, even while the result still
// waits there. Slots are handed out first by a fill counter and then from a free chain
// threaded through the link memory, so reset needs no clearing pass and the block is ready
// for an item as soon as reset is released.
`default_nettype none

module range_convoy_query_queue #(
    parameter int QUEUE_DEPTH = rcq_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_BITS    = rcq_pkg::TAG_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // query_tag, low_bound, low_is_null, high_bound, high_is_null, zero pad
    input  wire logic [rcq_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // action
    input  wire logic [1:0]                    s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // popped_tag, popped_low, popped_low_null, popped_high, popped_high_null,
    // occupancy, zero pad
    output logic [rcq_pkg::M_DATA_W-1:0]       m_axis_tdata,
    // status
    output logic [1:0]                         m_axis_tuser
);

    import rcq_pkg::*;

    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = TAG_BITS + 2 * BOUND_W;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);
    localparam int PAD_W   = M_DATA_W - (IN_TAG_W + 2 * BOUND_W + OCC_W);

    // entry and link memories
    logic [ENTRY_W-1:0] pl_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   lk_mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] pl_rdata;
    logic [PTR_W-1:0]   lk_rdata;
    logic [PTR_W-1:0]   rd_addr;
    logic               pl_we;
    logic [ENTRY_W-1:0] pl_wdata;
    logic               lk_we;
    logic [PTR_W-1:0]   lk_waddr;
    logic [PTR_W-1:0]   lk_wdata;

    // control state
    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   fresh_reg, fresh_next;
    logic [PTR_W-1:0]   free_head_reg, free_head_next;
    logic [PTR_W-1:0]   slot_reg, slot_next;
    logic [PTR_W-1:0]   cur_reg, cur_next;
    logic [PTR_W-1:0]   prev_reg, prev_next;
    logic               have_prev_reg, have_prev_next;
    logic [CNT_W-1:0]   walk_left_reg, walk_left_next;
    logic [PTR_W-1:0]   fix_addr_reg, fix_addr_next;
    logic               m_valid_reg, m_valid_next;

    // payload registers
    logic [1:0]          act_reg, act_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    bound_t              in_low_reg, in_low_next;
    bound_t              in_high_reg, in_high_next;
    logic [1:0]          res_status_reg, res_status_next;
    logic [IN_TAG_W-1:0] res_tag_reg, res_tag_next;
    bound_t              res_low_reg, res_low_next;
    bound_t              res_high_reg, res_high_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;
    logic [1:0]          m_user_reg, m_user_next;

    // decoded fields
    logic [31:0]         tag_in_wide;
    logic [31:0]         tag_out_wide;
    bound_t              s_low;
    bound_t              s_high;
    logic [TAG_BITS-1:0] rd_tag;
    bound_t              rd_low;
    bound_t              rd_high;
    logic [31:0]         occ_wide;
    logic                all_bounded;
    logic                go_after;
    logic                go_before;

    assign tag_in_wide  = 32'(s_axis_tdata[IN_TAG_W-1:0]);
    assign s_low        = '{is_null: s_axis_tdata[48], value: s_axis_tdata[47:16]};
    assign s_high       = '{is_null: s_axis_tdata[81], value: s_axis_tdata[80:49]};

    assign rd_low       = bound_t'(pl_rdata[BOUND_W-1:0]);
    assign rd_high      = bound_t'(pl_rdata[2*BOUND_W-1:BOUND_W]);
    assign rd_tag       = pl_rdata[ENTRY_W-1:2*BOUND_W];
    assign tag_out_wide = 32'(rd_tag);
    assign occ_wide     = 32'(count_reg);
    assign pl_wdata     = {tag_reg, in_high_reg, in_low_reg};

    // relation of the new query to the entry being visited
    assign all_bounded = !in_low_reg.is_null && !in_high_reg.is_null
                         && !rd_low.is_null && !rd_high.is_null;
    assign go_after  = bound_eq(in_high_reg, rd_high) || bound_eq(in_low_reg, rd_low)
                       || (all_bounded
                           && ($signed(in_high_reg.value) < $signed(rd_high.value))
                           && ($signed(in_low_reg.value) > $signed(rd_low.value)));
    assign go_before = all_bounded
                       && ($signed(in_high_reg.value) > $signed(rd_high.value))
                       && ($signed(in_low_reg.value) < $signed(rd_low.value));

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        fresh_next      = fresh_reg;
        free_head_next  = free_head_reg;
        slot_next       = slot_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        have_prev_next  = have_prev_reg;
        walk_left_next  = walk_left_reg;
        fix_addr_next   = fix_addr_reg;
        m_valid_next    = m_valid_reg;
        act_next        = act_reg;
        tag_next        = tag_reg;
        in_low_next     = in_low_reg;
        in_high_next    = in_high_reg;
        res_status_next = res_status_reg;
        res_tag_next    = res_tag_reg;
        res_low_next    = res_low_reg;
        res_high_next   = res_high_reg;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;
        rd_addr         = head_reg;
        pl_we           = 1'b0;
        lk_we           = 1'b0;
        lk_waddr        = tail_reg;
        lk_wdata        = slot_reg;

        if (m_valid_reg && m_axis_tready)
            m_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    act_next        = s_axis_tuser;
                    tag_next        = tag_in_wide[TAG_BITS-1:0];
                    in_low_next     = s_low;
                    in_high_next    = s_high;
                    res_status_next = STAT_OK;
                    res_tag_next    = '0;
                    res_low_next    = '0;
                    res_high_next   = '0;
                    if (s_axis_tuser == ACT_APPEND || s_axis_tuser == ACT_CONVOY)
                    begin
                        if (count_reg == FULL_COUNT)
                        begin
                            res_status_next = STAT_FULL;
                            state_next      = ST_DONE;
                        end
                        else if (fresh_reg != FULL_COUNT)
                        begin
                            slot_next  = fresh_reg[PTR_W-1:0];
                            fresh_next = fresh_reg + CNT_W'(1);
                            state_next = ST_WRITE;
                        end
                        else
                        begin
                            // take the slot at the head of the free chain
                            slot_next  = free_head_reg;
                            rd_addr    = free_head_reg;
                            state_next = ST_ALLOC;
                        end
                    end
                    else if (s_axis_tuser == ACT_POP)
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = STAT_EMPTY;
                            state_next      = ST_DONE;
                        end
                        else
                        begin
                            rd_addr    = head_reg;
                            state_next = ST_POP;
                        end
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_ALLOC:
            begin
                free_head_next = lk_rdata;
                state_next     = ST_WRITE;
            end

            ST_WRITE:
            begin
                pl_we = 1'b1;
                if (act_reg == ACT_APPEND || count_reg == '0)
                begin
                    if (count_reg == '0)
                        head_next = slot_reg;
                    else
                    begin
                        lk_we    = 1'b1;
                        lk_waddr = tail_reg;
                        lk_wdata = slot_reg;
                    end
                    tail_next  = slot_reg;
                    count_next = count_reg + CNT_W'(1);
                    state_next = ST_DONE;
                end
                else
                begin
                    rd_addr        = head_reg;
                    cur_next       = head_reg;
                    have_prev_next = 1'b0;
                    walk_left_next = count_reg - CNT_W'(1);
                    state_next     = ST_WALK;
                end
            end

            ST_WALK:
            begin
                if (go_after)
                begin
                    // splice in after the visited entry
                    lk_we         = 1'b1;
                    lk_waddr      = slot_reg;
                    lk_wdata      = lk_rdata;
                    fix_addr_next = cur_reg;
                    if (cur_reg == tail_reg)
                        tail_next = slot_reg;
                    count_next = count_reg + CNT_W'(1);
                    state_next = ST_LINK2;
                end
                else if (go_before)
                begin
                    lk_we      = 1'b1;
                    lk_waddr   = slot_reg;
                    lk_wdata   = cur_reg;
                    count_next = count_reg + CNT_W'(1);
                    if (have_prev_reg)
                    begin
                        fix_addr_next = prev_reg;
                        state_next    = ST_LINK2;
                    end
                    else
                    begin
                        head_next  = slot_reg;
                        state_next = ST_DONE;
                    end
                end
                else if (walk_left_reg == '0)
                begin
                    // no relative found: append at the tail
                    lk_we      = 1'b1;
                    lk_waddr   = tail_reg;
                    lk_wdata   = slot_reg;
                    tail_next  = slot_reg;
                    count_next = count_reg + CNT_W'(1);
                    state_next = ST_DONE;
                end
                else
                begin
                    prev_next      = cur_reg;
                    have_prev_next = 1'b1;
                    cur_next       = lk_rdata;
                    rd_addr        = lk_rdata;
                    walk_left_next = walk_left_reg - CNT_W'(1);
                end
            end

            ST_LINK2:
            begin
                lk_we      = 1'b1;
                lk_waddr   = fix_addr_reg;
                lk_wdata   = slot_reg;
                state_next = ST_DONE;
            end

            ST_POP:
            begin
                res_tag_next  = tag_out_wide[IN_TAG_W-1:0];
                res_low_next  = rd_low;
                res_high_next = rd_high;
                if (count_reg > CNT_W'(1))
                    head_next = lk_rdata;
                // return the slot to the free chain
                lk_we          = 1'b1;
                lk_waddr       = head_reg;
                lk_wdata       = free_head_reg;
                free_head_next = head_reg;
                count_next     = count_reg - CNT_W'(1);
                state_next     = ST_DONE;
            end

            ST_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_user_next  = res_status_reg;
                    m_data_next  = {{PAD_W{1'b0}}, occ_wide[OCC_W-1:0], res_high_reg,
                                    res_low_reg, res_tag_reg};
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            fresh_reg     <= '0;
            free_head_reg <= '0;
            slot_reg      <= '0;
            cur_reg       <= '0;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            walk_left_reg <= '0;
            fix_addr_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            fresh_reg     <= fresh_next;
            free_head_reg <= free_head_next;
            slot_reg      <= slot_next;
            cur_reg       <= cur_next;
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            walk_left_reg <= walk_left_next;
            fix_addr_reg  <= fix_addr_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        tag_reg        <= tag_next;
        in_low_reg     <= in_low_next;
        in_high_reg    <= in_high_next;
        res_status_reg <= res_status_next;
        res_tag_reg    <= res_tag_next;
        res_low_reg    <= res_low_next;
        res_high_reg   <= res_high_next;
        m_data_reg     <= m_data_next;
        m_user_reg     <= m_user_next;
    end

    always_ff @(posedge clk)
    begin
        if (pl_we)
            pl_mem[slot_reg] <= pl_wdata;
        pl_rdata <= pl_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (lk_we)
            lk_mem[lk_waddr] <= lk_wdata;
        lk_rdata <= lk_mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// Self-checking bench for range_convoy_query_queue: stream driver, result monitor and an
// ordered-list predictor of the plain, convoy and pop actions.
// Depends on rcq_pkg and the range_convoy_query_queue top level.
`timescale 1ns / 100ps

module tb_top;

    import rcq_pkg::*;

    localparam logic [1:0] ACT_IGNORED = 2'd3;
    localparam int         DEPTH       = QUEUE_DEPTH_DEF;
    localparam int         RANDOM_ITEMS = 1680;
    localparam int         CALM_ITEMS   = 150;
    localparam int         LONG_HOLD_AT = 300;
    localparam int         LONG_HOLD_CYCLES = 400;

    typedef struct {
        logic [1:0]          action;
        logic [IN_TAG_W-1:0] tag;
        bound_t              low;
        bound_t              high;
        bit                  calm;
        bit                  drain;
    } query_item_t;

    typedef struct {
        logic [IN_TAG_W-1:0] tag;
        bound_t              low;
        bound_t              high;
    } queued_query_t;

    typedef struct {
        logic [1:0]          status;
        logic [IN_TAG_W-1:0] tag;
        bound_t              low;
        bound_t              high;
        logic [OCC_W-1:0]    occ;
    } query_result_t;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    logic [1:0]          s_axis_tuser  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic [1:0]          m_axis_tuser;

    query_item_t   pending_q[$];
    query_result_t expected_q[$];
    queued_query_t model_list[$];

    bit sent_fire = 1'b0;
    bit rx_calm   = 1'b0;
    int gap_left  = 0;
    bit last_calm = 1'b0;
    int hold_left = 0;
    int stall_left = 0;
    bit long_hold_done = 1'b0;

    int mismatches   = 0;
    int items_taken  = 0;
    int results_seen = 0;
    int full_count   = 0;
    int empty_count  = 0;
    int convoy_count = 0;
    int max_occ      = 0;

    range_convoy_query_queue dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    function automatic bit bounds_match(input bound_t a, input bound_t b);
        if (a.is_null || b.is_null)
            return a.is_null && b.is_null;
        return a.value == b.value;
    endfunction

    // Apply one accepted action to the ordered list and return its result.
    function automatic query_result_t apply_query(input logic [1:0] action,
                                                  input logic [S_DATA_W-1:0] data);
        query_result_t res;
        queued_query_t nq;
        queued_query_t cur;
        int            slot;
        bit            all_set;
        bit            goes_after;
        res = '{status: STAT_OK, tag: '0, low: '0, high: '0, occ: '0};
        nq.tag  = data[15:0];
        nq.low  = '{is_null: data[48], value: data[47:16]};
        nq.high = '{is_null: data[81], value: data[80:49]};
        if (action == ACT_APPEND || action == ACT_CONVOY) begin
            if (model_list.size() >= DEPTH) begin
                res.status = STAT_FULL;
                full_count++;
            end else if (action == ACT_APPEND) begin
                model_list.push_back(nq);
            end else begin
                convoy_count++;
                slot = -1;
                for (int i = 0; i < model_list.size() && slot < 0; i++) begin
                    cur = model_list[i];
                    all_set = !nq.low.is_null && !nq.high.is_null &&
                              !cur.low.is_null && !cur.high.is_null;
                    goes_after = bounds_match(nq.high, cur.high) ||
                                 bounds_match(nq.low, cur.low) ||
                                 (all_set && $signed(nq.high.value) < $signed(cur.high.value)
                                          && $signed(nq.low.value) > $signed(cur.low.value));
                    if (goes_after)
                        slot = i + 1;
                    else if (all_set && $signed(nq.high.value) > $signed(cur.high.value)
                                     && $signed(nq.low.value) < $signed(cur.low.value))
                        slot = i;
                end
                if (slot < 0)
                    model_list.push_back(nq);
                else
                    model_list.insert(slot, nq);
            end
        end else if (action == ACT_POP) begin
            if (model_list.size() == 0) begin
                res.status = STAT_EMPTY;
                empty_count++;
            end else begin
                cur = model_list.pop_front();
                res.tag  = cur.tag;
                res.low  = cur.low;
                res.high = cur.high;
            end
        end
        res.occ = OCC_W'(model_list.size());
        if (model_list.size() > max_occ)
            max_occ = model_list.size();
        return res;
    endfunction

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
            mismatches++;
        end
    endtask

    // Check results first, then predict the item taken at this edge.
    always @(posedge clk) begin : monitor
        query_result_t want;
        query_result_t got;
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                got.status = m_axis_tuser;
                got.tag    = m_axis_tdata[15:0];
                got.low    = '{is_null: m_axis_tdata[48], value: m_axis_tdata[47:16]};
                got.high   = '{is_null: m_axis_tdata[81], value: m_axis_tdata[80:49]};
                got.occ    = m_axis_tdata[88:82];
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual status %0d tag %h",
                             $time, got.status, got.tag);
                    mismatches++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("popped_tag", want.tag, got.tag);
                    check_field("popped_low", want.low.value, got.low.value);
                    check_field("popped_low_null", want.low.is_null, got.low.is_null);
                    check_field("popped_high", want.high.value, got.high.value);
                    check_field("popped_high_null", want.high.is_null, got.high.is_null);
                    check_field("occupancy", want.occ, got.occ);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                items_taken++;
                expected_q.push_back(apply_query(s_axis_tuser, s_axis_tdata));
            end
            sent_fire <= s_axis_tvalid && s_axis_tready;
        end
    end

    always @(negedge clk) begin : driver
        query_item_t nxt;
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !sent_fire) begin
            // hold the item until it is taken
        end else begin
            if (sent_fire && !last_calm && $urandom_range(0, 3) == 0)
                gap_left = $urandom_range(1, 4);
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_q.size() == 0 ||
                         (pending_q[0].drain && expected_q.size() != 0)) begin
                s_axis_tvalid <= 1'b0;
            end else begin
                nxt = pending_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= nxt.action;
                s_axis_tdata  <= {6'b0, nxt.high.is_null, nxt.high.value,
                                  nxt.low.is_null, nxt.low.value, nxt.tag};
                last_calm = nxt.calm;
                rx_calm   <= nxt.calm;
            end
        end
    end

    always @(negedge clk) begin : receiver
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            // one long hold-off so the block backs up into its input
            if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (!rx_calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 3);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic bound_t make_bound(input bit is_null, input logic [31:0] value);
        bound_t b;
        b.is_null = is_null;
        b.value   = value;
        return b;
    endfunction

    function automatic bound_t rand_bound();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return make_bound(1'b1, $urandom);
        if (pick == 1)
            return make_bound(1'b0, $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000);
        if (pick <= 3)
            return make_bound(1'b0, $urandom);
        // narrow pool so bounds often share values or nest
        return make_bound(1'b0, $urandom_range(0, 16) - 8);
    endfunction

    task automatic add_query(input logic [1:0] action, input logic [15:0] tag,
                             input bound_t low, input bound_t high,
                             input bit calm, input bit drain);
        query_item_t q;
        q.action = action;
        q.tag    = tag;
        q.low    = low;
        q.high   = high;
        q.calm   = calm;
        q.drain  = drain;
        pending_q.push_back(q);
    endtask

    initial begin : reset_gen
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    initial begin : timeout
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        bound_t nb;
        bound_t lo;
        bound_t hi;
        int     push_pct;
        int     pick;
        bit     first_of_phase;
        logic [1:0] act;
        nb = make_bound(1'b1, 32'hDEAD_BEEF);

        // directed: empty pop, ignored code, extremes, nulls, nesting both ways
        add_query(ACT_POP, 16'h0000, nb, nb, 1'b0, 1'b0);
        add_query(ACT_IGNORED, 16'hFFFF, nb, nb, 1'b0, 1'b0);
        add_query(ACT_APPEND, 16'hFFFF, make_bound(1'b0, 0), make_bound(1'b0, 100), 1'b0, 1'b0);
        // contains the head: lands in front of it
        add_query(ACT_CONVOY, 16'h0001, make_bound(1'b0, -5), make_bound(1'b0, 200),
                  1'b0, 1'b0);
        add_query(ACT_CONVOY, 16'h0000, make_bound(1'b0, 32'h8000_0000),
                  make_bound(1'b0, 32'h7FFF_FFFF), 1'b0, 1'b0);
        // no relation to anything: appended
        add_query(ACT_CONVOY, 16'h0002, nb, make_bound(1'b1, 0), 1'b0, 1'b0);
        // null low equals null low: goes after the tail
        add_query(ACT_CONVOY, 16'h0003, make_bound(1'b1, 7), make_bound(1'b0, 5), 1'b0, 1'b0);
        add_query(ACT_CONVOY, 16'h0004, make_bound(1'b0, 0), make_bound(1'b0, 7), 1'b0, 1'b0);
        add_query(ACT_CONVOY, 16'h0005, make_bound(1'b0, 0), make_bound(1'b1, 1), 1'b0, 1'b0);
        add_query(ACT_APPEND, 16'h1234, make_bound(1'b0, -1), make_bound(1'b0, -1), 1'b0, 1'b0);
        add_query(ACT_CONVOY, 16'h5555, make_bound(1'b0, -1), make_bound(1'b0, 0), 1'b0, 1'b0);
        add_query(ACT_CONVOY, 16'hAAAA, make_bound(1'b0, 32'h7FFF_FFFF),
                  make_bound(1'b0, 32'h8000_0000), 1'b0, 1'b0);
        add_query(ACT_IGNORED, 16'h0000, nb, nb, 1'b0, 1'b0);
        repeat (13) add_query(ACT_POP, 16'h0000, nb, nb, 1'b0, 1'b0);

        push_pct = 55;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            first_of_phase = (i % 100 == 0);
            if (first_of_phase) begin
                pick = $urandom_range(0, 2);
                push_pct = (pick == 0) ? 85 : (pick == 1) ? 25 : 55;
            end
            pick = $urandom_range(0, 99);
            if (pick < 2)
                act = ACT_IGNORED;
            else if ($urandom_range(0, 99) < push_pct)
                act = ($urandom_range(0, 9) < 6) ? ACT_CONVOY : ACT_APPEND;
            else
                act = ACT_POP;
            lo = rand_bound();
            hi = rand_bound();
            // keep most ranges ordered so nesting is common
            if (!lo.is_null && !hi.is_null && $signed(lo.value) > $signed(hi.value)
                && $urandom_range(0, 4) != 0) begin
                nb = lo;
                lo = hi;
                hi = nb;
            end
            // no drain pauses once the calm tail of the run starts
            add_query(act, 16'($urandom_range(0, 16'hFFFF)), lo, hi,
                      i >= RANDOM_ITEMS - CALM_ITEMS,
                      (i == 0) || (first_of_phase && i < RANDOM_ITEMS - CALM_ITEMS
                                   && $urandom_range(0, 2) == 0));
        end

        while (pending_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (expected_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_q.size());
            mismatches++;
        end
        $display("Ran %0d actions with %0d results: %0d convoy pushes, peak occupancy %0d,",
                 items_taken, results_seen, convoy_count, max_occ);
        $display("%0d pushes refused as full, %0d pops refused as empty, %0d mismatches.",
                 full_count, empty_count, mismatches);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
